// File: hdl/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg
// Shared widths, codes and types of the reverse Polish stack evaluator.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int VALUE_W         = 48;
  localparam int CMD_W           = 3;
  localparam int STATUS_W        = 3;
  localparam int STACK_DEPTH     = 64;
  localparam int FRACTION_BITS   = 24;
  localparam int OPERAND_CEILING = 10;

  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int HALF_W      = VALUE_W / 2;
  localparam int PROD_W      = 2 * VALUE_W;
  localparam int DIV_W       = VALUE_W + FRACTION_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

  localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] OPERAND_LIMIT =
    VALUE_W'(OPERAND_CEILING) << FRACTION_BITS;

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_END  = 3'd5;

  typedef enum logic [2:0] {
    KIND_PUSH,
    KIND_ADD,
    KIND_SUB,
    KIND_MUL,
    KIND_DIV,
    KIND_END
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FEW     = 3'd1,
    ST_BIG     = 3'd2,
    ST_NOT_ONE = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_B,
    S_ARITH,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

  typedef struct packed {
    kind_t                     kind;
    logic                      too_big;
    logic signed [VALUE_W-1:0] operand;
  } entry_t;

endpackage

// File: hdl/rse_ifs.sv
// ----------------------------------------------------------------------------
// rse_cmd_if / rse_res_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface rse_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [rse_pkg::CMD_W-1:0]         command;
  logic signed [rse_pkg::VALUE_W-1:0] operand_value;

  modport source (output valid, command, operand_value, input ready);
  modport sink   (input valid, command, operand_value, output ready);
endinterface

interface rse_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [rse_pkg::VALUE_W-1:0] result_value;
  logic [rse_pkg::STATUS_W-1:0]      status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

// File: hdl/rse_front.sv
// ----------------------------------------------------------------------------
// rse_front
// Accepts command words, classifies them and checks push operands.
// ----------------------------------------------------------------------------
module rse_front (
  rse_cmd_if.sink          cmd,
  output logic             q_wr_valid,
  input  logic             q_wr_ready,
  output rse_pkg::entry_t  q_wr_data
);

  logic keep;

  always_comb begin
    keep              = 1'b1;
    q_wr_data.kind    = rse_pkg::KIND_PUSH;
    q_wr_data.operand = cmd.operand_value;
    q_wr_data.too_big = (cmd.operand_value >= rse_pkg::OPERAND_LIMIT);
    case (cmd.command)
      rse_pkg::CMD_PUSH: q_wr_data.kind = rse_pkg::KIND_PUSH;
      rse_pkg::CMD_ADD:  q_wr_data.kind = rse_pkg::KIND_ADD;
      rse_pkg::CMD_SUB:  q_wr_data.kind = rse_pkg::KIND_SUB;
      rse_pkg::CMD_MUL:  q_wr_data.kind = rse_pkg::KIND_MUL;
      rse_pkg::CMD_DIV:  q_wr_data.kind = rse_pkg::KIND_DIV;
      rse_pkg::CMD_END:  q_wr_data.kind = rse_pkg::KIND_END;
      default:           keep = 1'b0;
    endcase
  end

  // drop unknown commands on acceptance
  assign q_wr_valid = cmd.valid && keep;
  assign cmd.ready  = q_wr_ready;

endmodule

// File: hdl/rse_queue.sv
// ----------------------------------------------------------------------------
// rse_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module rse_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  rse_pkg::entry_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output rse_pkg::entry_t rd_data
);

  localparam int PTR_W  = $clog2(rse_pkg::QUEUE_DEPTH);
  localparam int FILL_W = $clog2(rse_pkg::QUEUE_DEPTH + 1);

  rse_pkg::entry_t   entries [rse_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [FILL_W-1:0] fill;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (fill != FILL_W'(rse_pkg::QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = entries[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wr_data;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(rse_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(rse_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: hdl/rse_back.sv
// ----------------------------------------------------------------------------
// rse_back
// Executes queued words on the value stack: push, add, subtract, a chunked
// multiplier, a bit-serial divider and the end-of-expression report.
// ----------------------------------------------------------------------------
module rse_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  rse_pkg::entry_t q_data,
  rse_res_if.source       res
);

  localparam int VW           = rse_pkg::VALUE_W;
  localparam int MUL_PRODUCTS = 4;
  localparam int MUL_LAST     = MUL_PRODUCTS + 1;

  function automatic logic [VW-1:0] sat_sum(input logic [VW:0] s);
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? rse_pkg::VALUE_MIN : rse_pkg::VALUE_MAX;
    end
    return s[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] sat_mag(input logic neg,
                                            input logic [rse_pkg::PROD_W-1:0] mag);
    logic big;
    big = |mag[rse_pkg::PROD_W-1:VW-1];
    if (neg) begin
      return big ? rse_pkg::VALUE_MIN : (~mag[VW-1:0] + 1'b1);
    end
    return big ? rse_pkg::VALUE_MAX : mag[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] mag_of(input logic [VW-1:0] v);
    return v[VW-1] ? (~v + 1'b1) : v;
  endfunction

  rse_pkg::state_t  state;
  rse_pkg::state_t  state_next;
  rse_pkg::status_t err;
  rse_pkg::status_t fin_status;
  rse_pkg::kind_t   kind;

  logic [rse_pkg::CNT_W-1:0] cnt;
  logic [rse_pkg::CNT_W-1:0] cnt_m1;
  logic [rse_pkg::CNT_W-1:0] cnt_m2;

  logic [VW-1:0] stack_mem [rse_pkg::STACK_DEPTH];
  logic [VW-1:0] rd_data;
  logic [VW-1:0] wr_data;
  logic [rse_pkg::ADDR_W-1:0] rd_addr;
  logic [rse_pkg::ADDR_W-1:0] wr_addr;
  logic rd_en;
  logic wr_en;

  logic [VW-1:0] a_val;
  logic          a_zero;
  logic [VW:0]   add_sum;
  logic [VW:0]   sub_sum;
  logic [VW-1:0] dz_res;

  logic                       neg;
  logic [VW-1:0]              mx;
  logic [VW-1:0]              my;
  logic [2:0]                 mul_step;
  logic [VW-1:0]              pp;
  logic [VW-1:0]              pp_next;
  logic [1:0]                 pp_pos;
  logic [rse_pkg::PROD_W-1:0] pp_shifted;
  logic [rse_pkg::PROD_W-1:0] acc;
  logic [rse_pkg::HALF_W-1:0] xh;
  logic [rse_pkg::HALF_W-1:0] yh;

  logic [rse_pkg::DIV_W-1:0]     dvd;
  logic [VW-1:0]                 rem;
  logic [VW-1:0]                 dsr;
  logic [rse_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [VW:0]                   rem_sh;
  logic [VW+1:0]                 diff;
  logic                          q_bit;

  logic          res_valid;
  logic [VW-1:0] res_value;
  logic [rse_pkg::STATUS_W-1:0] res_status;
  logic          slot_free;

  assign cnt_m1    = cnt - 1'b1;
  assign cnt_m2    = cnt - rse_pkg::CNT_W'(2);
  assign a_zero    = (a_val == '0);
  assign add_sum   = {rd_data[VW-1], rd_data} + {a_val[VW-1], a_val};
  assign sub_sum   = {rd_data[VW-1], rd_data} - {a_val[VW-1], a_val};
  assign dz_res    = rd_data[VW-1] ? rse_pkg::VALUE_MIN :
                     ((rd_data == '0) ? '0 : rse_pkg::VALUE_MAX);
  assign slot_free = !res_valid || res.ready;

  assign xh      = mul_step[1] ? mx[VW-1:rse_pkg::HALF_W] : mx[rse_pkg::HALF_W-1:0];
  assign yh      = mul_step[0] ? my[VW-1:rse_pkg::HALF_W] : my[rse_pkg::HALF_W-1:0];
  assign pp_next = VW'(xh * yh);

  always_comb begin
    case (pp_pos)
      2'd0:    pp_shifted = rse_pkg::PROD_W'(pp);
      2'd1:    pp_shifted = rse_pkg::PROD_W'(pp) << rse_pkg::HALF_W;
      default: pp_shifted = rse_pkg::PROD_W'(pp) << VW;
    endcase
  end

  assign rem_sh = {rem, dvd[rse_pkg::DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr};
  assign q_bit  = !diff[VW+1];

  always_comb begin
    if (err != rse_pkg::ST_OK) begin
      fin_status = err;
    end else if (cnt != rse_pkg::CNT_W'(1)) begin
      fin_status = rse_pkg::ST_NOT_ONE;
    end else begin
      fin_status = rse_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= stack_mem[rd_addr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rse_pkg::S_IDLE: begin
        if (q_valid) begin
          case (q_data.kind)
            rse_pkg::KIND_END: state_next = rse_pkg::S_FINISH;
            rse_pkg::KIND_PUSH: state_next = rse_pkg::S_IDLE;
            default: begin
              if (err == rse_pkg::ST_OK && cnt >= rse_pkg::CNT_W'(2)) begin
                state_next = rse_pkg::S_READ_B;
              end
            end
          endcase
        end
      end
      rse_pkg::S_READ_B: state_next = rse_pkg::S_ARITH;
      rse_pkg::S_ARITH: begin
        if (kind == rse_pkg::KIND_MUL) begin
          state_next = rse_pkg::S_MUL;
        end else if (kind == rse_pkg::KIND_DIV && !a_zero) begin
          state_next = rse_pkg::S_DIV;
        end else begin
          state_next = rse_pkg::S_IDLE;
        end
      end
      rse_pkg::S_MUL: begin
        if (mul_step == 3'(MUL_LAST)) begin
          state_next = rse_pkg::S_IDLE;
        end
      end
      rse_pkg::S_DIV: begin
        if (div_cnt == '0) begin
          state_next = rse_pkg::S_IDLE;
        end
      end
      rse_pkg::S_FINISH: begin
        if (slot_free) begin
          state_next = rse_pkg::S_IDLE;
        end
      end
      default: state_next = rse_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_ready = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = cnt_m2[rse_pkg::ADDR_W-1:0];
    wr_data = '0;
    case (state)
      rse_pkg::S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid && err == rse_pkg::ST_OK) begin
          case (q_data.kind)
            rse_pkg::KIND_END: begin
              rd_en = (cnt == rse_pkg::CNT_W'(1));
            end
            rse_pkg::KIND_PUSH: begin
              wr_en   = !q_data.too_big &&
                        (cnt != rse_pkg::CNT_W'(rse_pkg::STACK_DEPTH));
              wr_addr = cnt[rse_pkg::ADDR_W-1:0];
              wr_data = q_data.operand;
            end
            default: begin
              rd_en   = (cnt >= rse_pkg::CNT_W'(2));
              rd_addr = cnt_m1[rse_pkg::ADDR_W-1:0];
            end
          endcase
        end
      end
      rse_pkg::S_READ_B: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m2[rse_pkg::ADDR_W-1:0];
      end
      rse_pkg::S_ARITH: begin
        case (kind)
          rse_pkg::KIND_ADD: begin
            wr_en   = 1'b1;
            wr_data = sat_sum(add_sum);
          end
          rse_pkg::KIND_SUB: begin
            wr_en   = 1'b1;
            wr_data = sat_sum(sub_sum);
          end
          rse_pkg::KIND_DIV: begin
            wr_en   = a_zero;
            wr_data = dz_res;
          end
          default: wr_en = 1'b0;
        endcase
      end
      rse_pkg::S_MUL: begin
        wr_en   = (mul_step == 3'(MUL_LAST));
        wr_data = sat_mag(neg, acc >> rse_pkg::FRACTION_BITS);
      end
      rse_pkg::S_DIV: begin
        wr_en   = (div_cnt == '0);
        wr_data = sat_mag(neg, rse_pkg::PROD_W'(dvd));
      end
      default: q_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rse_pkg::S_IDLE;
      cnt       <= '0;
      err       <= rse_pkg::ST_OK;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rse_pkg::S_FINISH && slot_free) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        rse_pkg::S_IDLE: begin
          if (q_valid) begin
            kind <= q_data.kind;
            if (err == rse_pkg::ST_OK) begin
              case (q_data.kind)
                rse_pkg::KIND_END: ;
                rse_pkg::KIND_PUSH: begin
                  if (q_data.too_big) begin
                    err <= rse_pkg::ST_BIG;
                  end else if (cnt == rse_pkg::CNT_W'(rse_pkg::STACK_DEPTH)) begin
                    err <= rse_pkg::ST_FULL;
                  end else begin
                    cnt <= cnt + 1'b1;
                  end
                end
                default: begin
                  if (cnt < rse_pkg::CNT_W'(2)) begin
                    err <= rse_pkg::ST_FEW;
                  end
                end
              endcase
            end
          end
        end
        rse_pkg::S_READ_B: a_val <= rd_data;
        rse_pkg::S_ARITH: begin
          neg      <= rd_data[VW-1] ^ a_val[VW-1];
          mx       <= mag_of(rd_data);
          my       <= mag_of(a_val);
          mul_step <= '0;
          acc      <= '0;
          dvd      <= {mag_of(rd_data), {rse_pkg::FRACTION_BITS{1'b0}}};
          rem      <= '0;
          dsr      <= mag_of(a_val);
          div_cnt  <= rse_pkg::DIV_CNT_W'(rse_pkg::DIV_W);
          if (kind == rse_pkg::KIND_ADD || kind == rse_pkg::KIND_SUB ||
              (kind == rse_pkg::KIND_DIV && a_zero)) begin
            cnt <= cnt_m1;
          end
        end
        rse_pkg::S_MUL: begin
          mul_step <= mul_step + 1'b1;
          if (mul_step < 3'(MUL_PRODUCTS)) begin
            pp     <= pp_next;
            pp_pos <= 2'(mul_step[1]) + 2'(mul_step[0]);
          end
          if (mul_step != '0 && mul_step <= 3'(MUL_PRODUCTS)) begin
            acc <= acc + pp_shifted;
          end
          if (mul_step == 3'(MUL_LAST)) begin
            cnt <= cnt_m1;
          end
        end
        rse_pkg::S_DIV: begin
          if (div_cnt != '0) begin
            dvd     <= {dvd[rse_pkg::DIV_W-2:0], q_bit};
            rem     <= q_bit ? diff[VW-1:0] : rem_sh[VW-1:0];
            div_cnt <= div_cnt - 1'b1;
          end else begin
            cnt <= cnt_m1;
          end
        end
        rse_pkg::S_FINISH: begin
          if (slot_free) begin
            res_status <= fin_status;
            res_value  <= (fin_status == rse_pkg::ST_OK) ? rd_data : '0;
            cnt        <= '0;
            err        <= rse_pkg::ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  assign res.valid        = res_valid;
  assign res.result_value = res_value;
  assign res.status       = res_status;

endmodule

// File: hdl/rpn_stack_evaluator.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Reverse Polish evaluator on a bounded stack of signed Q24.24 values.
//
//   channel  dir  words                          carries
//   cmd      in   one per token                  command, operand_value
//   res      out  one per end-of-expression word result_value, status
//
// Multiply sums four 24x24 partial products; divide forms one quotient bit
// a cycle over 72 bits. The back takes no new word until it is done.
// A two-word queue separates the front from the back; the result register
// lets work go on while a report waits, and a second end word then stalls.
// Synchronous reset empties the stack and clears any pending error.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator (
  input  logic clk,
  input  logic rst,
  rse_cmd_if.sink   cmd,
  rse_res_if.source res
);

  logic            fq_valid;
  logic            fq_ready;
  rse_pkg::entry_t fq_data;
  logic            qb_valid;
  logic            qb_ready;
  rse_pkg::entry_t qb_data;

  rse_front u_front (
    .cmd        (cmd),
    .q_wr_valid (fq_valid),
    .q_wr_ready (fq_ready),
    .q_wr_data  (fq_data)
  );

  rse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  rse_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (qb_valid),
    .q_ready (qb_ready),
    .q_data  (qb_data),
    .res     (res)
  );

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the reverse Polish stack evaluator. A mirror of the
// stack and the first error is kept beside the block and updated on every
// accepted command word; the report it forms on each end word is compared
// with the result word that comes out. Directed expressions cover saturation
// and all errors but ST_FULL, then random expressions, deep stacks, broken
// sequences and noise follow, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rse_pkg::*;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
  } report_t;

  class expr_checker;
    logic signed [VALUE_W-1:0] stack_mem [STACK_DEPTH];
    int unsigned               depth_cnt;
    status_t                   first_err;
    report_t                   pending_reports [$];
    int unsigned               fail_count;

    function new();
      depth_cnt  = 0;
      first_err  = ST_OK;
      fail_count = 0;
    endfunction

    task report(input string msg);
      fail_count++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function logic [VALUE_W-1:0] magnitude(input logic signed [VALUE_W-1:0] v);
      return v[VALUE_W-1] ? -v : v;
    endfunction

    function logic signed [VALUE_W-1:0] from_magnitude(input bit neg,
                                                       input logic [PROD_W-1:0] mag);
      logic [PROD_W-1:0] lim;
      lim = PROD_W'(1) << (VALUE_W - 1);
      if (neg) return (mag >= lim) ? VALUE_MIN : -mag[VALUE_W-1:0];
      return (mag > lim - 1) ? VALUE_MAX : mag[VALUE_W-1:0];
    endfunction

    function logic signed [VALUE_W-1:0] clamp_sum(input longint s);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (VALUE_W - 1)) - 1;
      lo = -(longint'(1) <<< (VALUE_W - 1));
      if (s > hi) return VALUE_MAX;
      if (s < lo) return VALUE_MIN;
      return s[VALUE_W-1:0];
    endfunction

    function logic signed [VALUE_W-1:0] combine(input logic [CMD_W-1:0] op,
                                                input logic signed [VALUE_W-1:0] b,
                                                input logic signed [VALUE_W-1:0] a);
      longint            lb;
      longint            la;
      logic [PROD_W-1:0] mb;
      logic [PROD_W-1:0] ma;
      logic [PROD_W-1:0] wide;
      bit                neg;
      lb  = b;
      la  = a;
      mb  = {{VALUE_W{1'b0}}, magnitude(b)};
      ma  = {{VALUE_W{1'b0}}, magnitude(a)};
      neg = b[VALUE_W-1] != a[VALUE_W-1];
      case (op)
        CMD_ADD: return clamp_sum(lb + la);
        CMD_SUB: return clamp_sum(lb - la);
        CMD_MUL: begin
          wide = (mb * ma) >> FRACTION_BITS;
          return from_magnitude(neg, wide);
        end
        default: begin
          if (a == 0) begin
            if (lb > 0) return VALUE_MAX;
            if (lb < 0) return VALUE_MIN;
            return '0;
          end
          wide = (mb << FRACTION_BITS) / ma;
          return from_magnitude(neg, wide);
        end
      endcase
    endfunction

    function void absorb_token(input logic [CMD_W-1:0] c,
                               input logic signed [VALUE_W-1:0] v);
      report_t rep;
      if (c == CMD_END) begin
        rep.value  = '0;
        rep.status = first_err;
        if (first_err == ST_OK) begin
          if (depth_cnt != 1) rep.status = ST_NOT_ONE;
          else rep.value = stack_mem[0];
        end
        pending_reports.push_back(rep);
        depth_cnt = 0;
        first_err = ST_OK;
        return;
      end
      if (c > CMD_END || first_err != ST_OK) return;
      if (c == CMD_PUSH) begin
        if (v >= OPERAND_LIMIT) first_err = ST_BIG;
        else if (depth_cnt >= STACK_DEPTH) first_err = ST_FULL;
        else begin
          stack_mem[depth_cnt] = v;
          depth_cnt++;
        end
        return;
      end
      if (depth_cnt < 2) begin
        first_err = ST_FEW;
        return;
      end
      stack_mem[depth_cnt-2] = combine(c, stack_mem[depth_cnt-2], stack_mem[depth_cnt-1]);
      depth_cnt--;
    endfunction

    task check_report(input logic signed [VALUE_W-1:0] value,
                      input logic [STATUS_W-1:0] status);
      report_t want;
      if (pending_reports.size() == 0) begin
        report($sformatf("result word with nothing expected: value %0d status %0d",
                         value, status));
        return;
      end
      want = pending_reports.pop_front();
      if (value !== want.value)
        report($sformatf("result_value %0d, expected %0d", value, want.value));
      if (status !== want.status)
        report($sformatf("status %0d, expected %0d", status, want.status));
    endtask
  endclass

  logic clk;
  logic rst;
  bit   quiet;
  bit   gaps_on;
  int   tokens_sent;
  int   stall_left;

  expr_checker checker_h;

  rse_cmd_if cmd_bus ();
  rse_res_if res_bus ();

  rpn_stack_evaluator u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_bus.valid && res_bus.ready)
        checker_h.check_report(res_bus.result_value, res_bus.status);
      if (cmd_bus.valid && cmd_bus.ready)
        checker_h.absorb_token(cmd_bus.command, cmd_bus.operand_value);
    end
  end

  initial begin
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [VALUE_W-1:0] full_random();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[VALUE_W-1:0];
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_operand();
    logic [VALUE_W-1:0] off;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: begin
        off = $urandom_range(0, 32'd335544319);
        return off - (VALUE_W'(OPERAND_CEILING) << FRACTION_BITS);
      end
      8, 9:   return '0;
      10, 11: return VALUE_W'(signed'($urandom_range(0, 19)) - 10) <<< FRACTION_BITS;
      12, 13, 14: return full_random() | VALUE_MIN;
      15, 16: return VALUE_W'(signed'($urandom_range(0, 511)) - 256);
      17:     return OPERAND_LIMIT - 1;
      18:     return $urandom_range(0, 1) ? OPERAND_LIMIT : OPERAND_LIMIT - 1;
      default: return full_random();
    endcase
  endfunction

  task automatic send_token(input logic [CMD_W-1:0] c,
                            input logic signed [VALUE_W-1:0] v);
    int gap;
    gap = 0;
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    @(negedge clk);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_bus.valid         <= 1'b1;
    cmd_bus.command       <= c;
    cmd_bus.operand_value <= v;
    do @(posedge clk); while (!cmd_bus.ready);
    if (c <= CMD_END) tokens_sent++;
  endtask

  task automatic send_noise(input int len, input int top_cmd);
    int k;
    for (k = 0; k < len; k++)
      send_token(CMD_W'($urandom_range(0, top_cmd)),
                 $urandom_range(0, 1) ? full_random() : rand_operand());
  endtask

  task automatic send_expression(input int n_operands, input bit pushes_first,
                                 input bit leave_two, input int noise_pct);
    int pushes_left;
    int depth;
    pushes_left = n_operands;
    depth       = 0;
    while (pushes_left > 0 || depth > 1) begin
      if (leave_two && pushes_left == 0 && depth == 2) break;
      if ($urandom_range(0, 99) < noise_pct) send_noise(1, 7);
      if (depth < 2 || (pushes_left > 0 && (pushes_first || $urandom_range(0, 1)))) begin
        send_token(CMD_PUSH, rand_operand());
        pushes_left--;
        depth++;
      end else begin
        send_token(CMD_W'(CMD_ADD + $urandom_range(0, 3)), full_random());
        depth--;
      end
    end
    send_token(CMD_END, full_random());
  endtask

  initial begin
    int pick;
    rst                   = 1'b1;
    quiet                 = 1'b0;
    gaps_on               = 1'b1;
    tokens_sent           = 0;
    cmd_bus.valid         = 1'b0;
    cmd_bus.command       = CMD_PUSH;
    cmd_bus.operand_value = '0;
    res_bus.ready         = 1'b0;
    checker_h             = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty stack, then operand too big with a frozen push behind it
    send_token(CMD_END, '0);
    send_token(CMD_PUSH, OPERAND_LIMIT);
    send_token(CMD_PUSH, 48'sd1 <<< FRACTION_BITS);
    send_token(CMD_END, '0);
    // too few operands
    send_token(CMD_PUSH, 48'sd1 <<< FRACTION_BITS);
    send_token(CMD_ADD, '0);
    send_token(CMD_END, '0);
    // extremes through add, subtract and multiply
    send_token(CMD_PUSH, OPERAND_LIMIT - 1);
    send_token(CMD_PUSH, VALUE_MIN);
    send_token(CMD_ADD, full_random());
    send_token(CMD_END, '0);
    send_token(CMD_PUSH, VALUE_MIN);
    send_token(CMD_PUSH, 48'sd1);
    send_token(CMD_SUB, full_random());
    send_token(CMD_END, '0);
    send_token(CMD_PUSH, VALUE_MIN);
    send_token(CMD_PUSH, -(48'sd1 <<< FRACTION_BITS));
    send_token(CMD_MUL, full_random());
    send_token(CMD_END, '0);
    // zero over zero
    send_token(CMD_PUSH, '0);
    send_token(CMD_PUSH, '0);
    send_token(CMD_DIV, full_random());
    send_token(CMD_END, '0);
    // unknown commands are dropped
    send_token(CMD_PUSH, 48'sd7 <<< FRACTION_BITS);
    send_token(CMD_W'(6), full_random());
    send_token(CMD_W'(7), full_random());
    send_token(CMD_END, '0);

    tokens_sent = 0;
    while (tokens_sent < 1600) begin
      quiet   = tokens_sent >= 1360;
      gaps_on = $urandom_range(0, 9) < 7;
      pick    = $urandom_range(0, 99);
      if (pick < 68)
        send_expression($urandom_range(1, 8), 1'b0, 1'b0, 3);
      else if (pick < 78)
        send_expression($urandom_range(2, 8), 1'b0, 1'b1, 0);
      else if (pick < 80)
        send_expression($urandom_range(62, 66), 1'b1, 1'b0, 0);
      else if (pick < 92) begin
        send_noise($urandom_range(1, 6), 4);
        send_token(CMD_END, full_random());
      end else
        send_noise($urandom_range(1, 4), 7);
    end
    send_token(CMD_END, full_random());
    @(negedge clk);
    cmd_bus.valid <= 1'b0;

    while (checker_h.pending_reports.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (checker_h.fail_count == 0 && checker_h.pending_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
